// ===== src/sec_pkg.sv =====
// Package for the sound event counter: shared types, widths and register codes.
// No dependencies; imported by every module of the block.
`default_nettype none

package sec_pkg;

  localparam int unsigned BLOCK_SAMPLES_DEF = 256;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned MAG_W    = 17;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned SS_W     = 9;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_CNT_W = $clog2(SUM_W);
  localparam int unsigned Q_DEPTH  = 2;

  localparam logic [15:0] THRESH_RST   = 16'd3000;
  localparam logic [15:0] COOLDOWN_RST = 16'd2000;
  localparam logic [15:0] LONGPR_RST   = 16'd2000;
  localparam logic [15:0] FLIPLIM_RST  = 16'hD334;  // -11468, -0.7 g

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_LIMIT = 2'd3;

  typedef enum logic [1:0] {
    OP_AUDIO  = 2'd0,
    OP_TICK   = 2'd1,
    OP_BUTTON = 2'd2,
    OP_ACCEL  = 2'd3
  } op_t;

  // Classified item as it travels from front to back.
  typedef struct packed {
    op_t                op;
    logic [MAG_W-1:0]   mag;
    logic               last;
    logic               btn_low;
    logic signed [15:0] accel;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_FIN
  } bstate_t;

endpackage

`default_nettype wire

// ===== src/sec_front.sv =====
// Front end: takes input transactions, extracts the sample magnitude, pushes a command.
// Depends on sec_pkg.
`default_nettype none

module sec_front import sec_pkg::*; (
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_op,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_word,
  input  wire logic                       in_last_sample,
  input  wire logic                       in_button_low,
  input  wire logic signed [15:0]         in_accel_z,
  input  wire logic                       q_full,
  output logic                            q_push,
  output cmd_t                            q_wdata
);

  logic [LEVEL_W-1:0] smp;
  logic [MAG_W-1:0]   smp_ext;

  assign smp     = in_sample_word[23:8];
  assign smp_ext = {smp[LEVEL_W-1], smp};

  always_comb begin
    q_wdata.op      = op_t'(in_op);
    // -32768 gives 32768, hence the extra bit
    q_wdata.mag     = smp[LEVEL_W-1] ? (MAG_W'(0) - smp_ext) : smp_ext;
    q_wdata.last    = in_last_sample;
    q_wdata.btn_low = in_button_low;
    q_wdata.accel   = in_accel_z;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

endmodule

`default_nettype wire

// ===== src/sec_queue.sv =====
// Short command queue between front and back ends.
// Depends on sec_pkg.
`default_nettype none

module sec_queue import sec_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      wdata,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      rdata
);

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(Q_DEPTH + 1);

  cmd_t              mem [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  assign full    = (fill_r == FILL_W'(Q_DEPTH));
  assign q_valid = (fill_r != '0);
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    fill_nxt = fill_r + FILL_W'(push) - FILL_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !pop)
    else $error("queue pop while empty");
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> fill_r == $past(fill_r) + FILL_W'(1))
    else $error("queue fill count lost a push");

endmodule

`default_nettype wire

// ===== src/sec_back.sv =====
// Back end: executes commands, runs the serial block-mean divider, holds the result register.
// Also holds the configuration registers. Depends on sec_pkg.
`default_nettype none

module sec_back import sec_pkg::*; #(
  parameter int unsigned BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 q_valid,
  input  cmd_t                      q_rdata,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [CNT_W-1:0]          out_event_count,
  output logic                      out_triggered,
  output logic [LEVEL_W-1:0]        out_block_energy,
  output logic                      out_block_done,
  output logic                      out_listening,
  output logic                      out_flipped,
  output logic                      out_counter_cleared
);

  // configuration
  logic [15:0]        thresh_r, cooldown_r, long_press_r;
  logic signed [15:0] flip_limit_r;

  bstate_t state_r, state_nxt;

  logic [TIME_W-1:0]  now_r, now_nxt;
  logic [TIME_W-1:0]  last_trig_r, last_trig_nxt;
  logic [TIME_W-1:0]  press_start_r, press_start_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SS_W-1:0]    ss_r, ss_nxt;
  logic [LEVEL_W-1:0] energy_r, energy_nxt;
  logic               listen_r, listen_nxt;
  logic               flip_r, flip_nxt;
  logic               held_r, held_nxt;

  // divider: quotient shifts into the dividend register
  logic [SUM_W-1:0]     num_r, num_nxt;
  logic [SS_W-1:0]      den_r, den_nxt;
  logic [SS_W-1:0]      rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic [SS_W:0]        rem_sh;

  logic out_valid_r, out_valid_nxt;
  logic ld, ld_trig, ld_done, ld_clr;
  logic out_free;

  logic [TIME_W-1:0] since_trig, since_press;
  logic [SUM_W-1:0]  sum_add;
  logic [SS_W-1:0]   ss_add;

  logic [CNT_W-1:0]   oc_r;
  logic [LEVEL_W-1:0] oe_r;
  logic               ot_r, od_r, ol_r, of_r, ocl_r;

  assign out_free    = !out_valid_r || out_ready;
  assign since_trig  = now_r - last_trig_r;
  assign since_press = now_r - press_start_r;
  assign sum_add     = sum_r + SUM_W'(q_rdata.mag);
  assign ss_add      = ss_r + SS_W'(1);
  assign rem_sh      = {rem_r, num_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    now_nxt         = now_r;
    last_trig_nxt   = last_trig_r;
    press_start_nxt = press_start_r;
    count_nxt       = count_r;
    sum_nxt         = sum_r;
    ss_nxt          = ss_r;
    energy_nxt      = energy_r;
    listen_nxt      = listen_r;
    flip_nxt        = flip_r;
    held_nxt        = held_r;
    num_nxt         = num_r;
    den_nxt         = den_r;
    rem_nxt         = rem_r;
    dcnt_nxt        = dcnt_r;
    q_pop           = 1'b0;
    ld              = 1'b0;
    ld_trig         = 1'b0;
    ld_done         = 1'b0;
    ld_clr          = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_rdata.op)
            OP_AUDIO: begin
              if (q_rdata.last || (ss_add >= SS_W'(BLOCK_SAMPLES))) begin
                num_nxt   = sum_add;
                den_nxt   = (ss_add == '0) ? SS_W'(1) : ss_add;
                rem_nxt   = '0;
                dcnt_nxt  = '0;
                sum_nxt   = '0;
                ss_nxt    = '0;
                state_nxt = B_DIV;
              end else begin
                sum_nxt = sum_add;
                ss_nxt  = ss_add;
                ld      = 1'b1;
              end
            end
            OP_TICK: begin
              now_nxt = now_r + TIME_W'(1);
              ld      = 1'b1;
            end
            OP_BUTTON: begin
              ld = 1'b1;
              if (q_rdata.btn_low) begin
                if (!held_r) begin
                  press_start_nxt = now_r;
                  held_nxt        = 1'b1;
                end else if (since_press > TIME_W'(long_press_r)) begin
                  count_nxt = '0;
                  held_nxt  = 1'b0;
                  ld_clr    = 1'b1;
                end
              end else if (held_r) begin
                // short release toggles; exactly the long-press time does nothing
                if (since_press < TIME_W'(long_press_r)) begin
                  listen_nxt = !listen_r;
                end
                held_nxt = 1'b0;
              end
            end
            OP_ACCEL: begin
              flip_nxt = (q_rdata.accel < flip_limit_r);
              ld       = 1'b1;
            end
          endcase
        end
      end
      B_DIV: begin
        if (rem_sh >= {1'b0, den_r}) begin
          rem_nxt = SS_W'(rem_sh - {1'b0, den_r});
          num_nxt = {num_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[SS_W-1:0];
          num_nxt = {num_r[SUM_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + DIV_CNT_W'(1);
        if (dcnt_r == DIV_CNT_W'(SUM_W - 1)) begin
          state_nxt = B_FIN;
        end
      end
      B_FIN: begin
        if (out_free) begin
          energy_nxt = num_r[LEVEL_W-1:0];
          ld         = 1'b1;
          ld_done    = 1'b1;
          if (!flip_r && listen_r && (num_r[LEVEL_W-1:0] > thresh_r)
              && (since_trig > TIME_W'(cooldown_r))) begin
            last_trig_nxt = now_r;
            count_nxt     = count_r + CNT_W'(1);
            ld_trig       = 1'b1;
          end
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || ld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r         <= '0;
      last_trig_r   <= '0;
      press_start_r <= '0;
      count_r       <= '0;
      sum_r         <= '0;
      ss_r          <= '0;
      energy_r      <= '0;
      listen_r      <= 1'b1;
      flip_r        <= 1'b0;
      held_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      dcnt_r        <= '0;
    end else begin
      now_r         <= now_nxt;
      last_trig_r   <= last_trig_nxt;
      press_start_r <= press_start_nxt;
      count_r       <= count_nxt;
      sum_r         <= sum_nxt;
      ss_r          <= ss_nxt;
      energy_r      <= energy_nxt;
      listen_r      <= listen_nxt;
      flip_r        <= flip_nxt;
      held_r        <= held_nxt;
      out_valid_r   <= out_valid_nxt;
      dcnt_r        <= dcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r     <= THRESH_RST;
      cooldown_r   <= COOLDOWN_RST;
      long_press_r <= LONGPR_RST;
      flip_limit_r <= FLIPLIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:  thresh_r     <= cfg_wdata;
        REG_COOLDOWN:   cooldown_r   <= cfg_wdata;
        REG_LONG_PRESS: long_press_r <= cfg_wdata;
        REG_FLIP_LIMIT: flip_limit_r <= cfg_wdata;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (ld) begin
      oc_r  <= count_nxt;
      ot_r  <= ld_trig;
      oe_r  <= energy_nxt;
      od_r  <= ld_done;
      ol_r  <= listen_nxt;
      of_r  <= flip_nxt;
      ocl_r <= ld_clr;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_count     = oc_r;
  assign out_triggered       = ot_r;
  assign out_block_energy    = oe_r;
  assign out_block_done      = od_r;
  assign out_listening       = ol_r;
  assign out_flipped         = of_r;
  assign out_counter_cleared = ocl_r;

  a_trig_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && ld_trig) |-> ld_done)
    else $error("trigger outside a block close");
  a_trig_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && ld_trig) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("trigger did not advance the counter");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV && dcnt_r == DIV_CNT_W'(SUM_W - 1)) |=> state_r == B_FIN)
    else $error("divider ran past its last step");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != B_IDLE) |-> !q_pop)
    else $error("command taken while divider busy");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !ld)
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

// ===== src/sound_event_counter_with_holdoff.sv =====
// Top level of the sound event counter with hold-off.
// Depends on sec_pkg, sec_front, sec_queue and sec_back.
//
//  channel  ports                           direction  handshake
//  in       in_op .. in_accel_z             input      in_valid / in_ready
//  out      out_event_count .. out_counter_cleared  output  out_valid / out_ready
//  cfg      cfg_index, cfg_wdata            input      cfg_we, no wait
//
// Ticks, button and accelerometer items are each handled as the back end pops them while idle.
// An audio item that closes a block is accumulated while idle, then runs through the
// bit-serial restoring divider (one quotient bit per cycle) and is decided in the final state.
// Items queue in a two-entry buffer, so the input keeps taking transactions, until the
// buffer fills, while the back end divides or the result register waits on out_ready.
// Reset (rst_n low, synchronous) restores the register defaults and listening on.
`default_nettype none

module sound_event_counter_with_holdoff import sec_pkg::*; #(
  parameter int unsigned BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_wdata,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 in_op,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_word,
  input  wire logic                       in_last_sample,
  input  wire logic                       in_button_low,
  input  wire logic signed [15:0]         in_accel_z,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [CNT_W-1:0]                out_event_count,
  output logic                            out_triggered,
  output logic [LEVEL_W-1:0]              out_block_energy,
  output logic                            out_block_done,
  output logic                            out_listening,
  output logic                            out_flipped,
  output logic                            out_counter_cleared
);

  logic q_full, q_push, q_pop, q_valid;
  cmd_t q_wdata, q_rdata;

  sec_front u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_sample_word (in_sample_word),
    .in_last_sample (in_last_sample),
    .in_button_low  (in_button_low),
    .in_accel_z     (in_accel_z),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_wdata        (q_wdata)
  );

  sec_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wdata   (q_wdata),
    .full    (q_full),
    .pop     (q_pop),
    .q_valid (q_valid),
    .rdata   (q_rdata)
  );

  sec_back #(
    .BLOCK_SAMPLES (BLOCK_SAMPLES)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .q_valid             (q_valid),
    .q_rdata             (q_rdata),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_count     (out_event_count),
    .out_triggered       (out_triggered),
    .out_block_energy    (out_block_energy),
    .out_block_done      (out_block_done),
    .out_listening       (out_listening),
    .out_flipped         (out_flipped),
    .out_counter_cleared (out_counter_cleared)
  );

endmodule

`default_nettype wire
